>>> sv/stream_pattern_masker_core_macros.svh
// ---------------------------------------------------------------------------
// Stream pattern masker - assertion macros
// Shorthand for the concurrent checks in the masker core. Each macro expects
// clk and rst_n in scope and is used on a line of its own.
// ---------------------------------------------------------------------------
`ifndef STREAM_PATTERN_MASKER_CORE_MACROS_SVH
`define STREAM_PATTERN_MASKER_CORE_MACROS_SVH

// Condition that must hold at every clock edge out of reset
`define SPM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition that must hold in the cycle after the trigger
`define SPM_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

>>> sv/spm_pkg.sv
// ---------------------------------------------------------------------------
// Stream pattern masker - package
// Shared widths, constants, register indexes and the output item type.
// ---------------------------------------------------------------------------
package spm_pkg;

  localparam int BYTE_W          = 8;
  localparam int LEN_W           = 5;   // pattern length and window counts
  localparam int PAT_CAP         = 16;  // bytes held by the two pattern registers
  localparam int PAT_IDX_W       = 4;
  localparam int MAX_PATTERN_DEF = 16;
  localparam int CFG_ADDR_W      = 2;
  localparam int CFG_DATA_W      = 64;

  localparam logic [BYTE_W-1:0] MASK_BYTE = 8'd42;  // '*'
  localparam logic [LEN_W-1:0]  PAT_CAP_L = LEN_W'(PAT_CAP);

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PAT_LO  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PAT_HI  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PAT_LEN = 2'd2;

  // One result item on its way out
  typedef struct packed {
    logic              last;
    logic [BYTE_W-1:0] data;
  } out_item_t;

endpackage

>>> sv/stream_pattern_masker_core.sv
// ---------------------------------------------------------------------------
// Stream pattern masker core
// Passes a byte stream through and replaces every leftmost, non-overlapping
// occurrence of the configured pattern (up to 16 bytes) by '*' bytes.
//
//   channel | direction | fields
//   --------+-----------+--------------------------------------------------
//   in_     | sink      | tdata = in_byte[7:0], tlast = in_last
//   out_    | source    | tdata = out_byte[7:0], tlast = out_last
//   cfg_    | sink      | addr 0: pattern low, 1: pattern high, 2: length
//
// One byte per cycle in steady state: the window compare is one pass of
// parallel byte compares between the window shift line and the pattern registers.
// A transaction releasing more than one held byte (end of stream, length cut,
// zero length) blocks the input while they drain, reopening it as the last drains.
// Results leave through a two-entry output buffer; a stalled output only
// backs up into the input once that buffer is full.
// Reset is synchronous; no clearing pass is needed.
// ---------------------------------------------------------------------------
`include "stream_pattern_masker_core_macros.svh"

module stream_pattern_masker_core #(
  parameter int MAX_PATTERN = spm_pkg::MAX_PATTERN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [spm_pkg::BYTE_W-1:0]     in_tdata,   // [7:0] in_byte
  input  logic                           in_tlast,
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [spm_pkg::BYTE_W-1:0]     out_tdata,  // [7:0] out_byte
  output logic                           out_tlast,
  // configuration
  input  logic                           cfg_we,
  input  logic [spm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [spm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import spm_pkg::*;

  localparam int DEPTH = (MAX_PATTERN < PAT_CAP) ? MAX_PATTERN : PAT_CAP;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(DEPTH);

  // Configuration registers
  logic [CFG_DATA_W-1:0] pat_lo_r, pat_hi_r;
  logic [LEN_W-1:0]      pat_len_r;

  // Window line, newest byte at index 0; released bytes sit above the window
  logic [BYTE_W-1:0] win_byte_r [DEPTH];
  logic [BYTE_W-1:0] win_byte_nxt [DEPTH];
  logic [DEPTH-1:0]  win_mask_r, win_mask_nxt;
  logic [LEN_W-1:0]  win_fill_r, win_fill_nxt;
  logic [LEN_W-1:0]  rel_cnt_r, rel_cnt_nxt;
  logic              rel_last_r, rel_last_nxt;
  logic [LEN_W-1:0]  bsm_r, bsm_nxt;

  // Output buffer
  out_item_t   ob_head_r, ob_head_nxt, ob_tail_r, ob_tail_nxt;
  logic [1:0]  ob_cnt_r, ob_cnt_nxt;

  logic [LEN_W-1:0]     eff_len, total, nf, bsm_inc, released;
  logic [IDX_W-1:0]     oldest_idx;
  logic                 drain_go, in_acc, pop, hit;
  out_item_t            drain_item;
  logic [2*CFG_DATA_W-1:0] pat_all;
  logic [BYTE_W-1:0]    sh_byte [DEPTH];
  logic [DEPTH-1:0]     sh_mask, eq;

  // Effective pattern length and drain side
  always_comb begin
    eff_len    = (pat_len_r > DEPTH_L) ? DEPTH_L : pat_len_r;
    total      = win_fill_r + rel_cnt_r;
    oldest_idx = IDX_W'(total - LEN_W'(1));
    drain_go   = (rel_cnt_r != '0) && (ob_cnt_r != 2'd2);
    drain_item.data = win_mask_r[oldest_idx] ? MASK_BYTE : win_byte_r[oldest_idx];
    drain_item.last = rel_last_r && (rel_cnt_r == LEN_W'(1));
    in_tready  = (rel_cnt_r == '0) || ((rel_cnt_r == LEN_W'(1)) && drain_go);
    in_acc     = in_tvalid && in_tready;
  end

  // Shift the new byte in and compare the newest eff_len bytes
  always_comb begin
    logic [PAT_IDX_W-1:0] k;
    logic [BYTE_W-1:0]    pb;
    pat_all = {pat_hi_r, pat_lo_r};
    nf      = win_fill_r + LEN_W'(1);
    bsm_inc = (bsm_r < PAT_CAP_L) ? bsm_r + LEN_W'(1) : bsm_r;
    for (int j = 0; j < DEPTH; j++) begin
      if (j == 0) begin
        sh_byte[j] = in_tdata;
        sh_mask[j] = 1'b0;
      end else begin
        sh_byte[j] = win_byte_r[j-1];
        sh_mask[j] = win_mask_r[j-1];
      end
      // window entry j lines up with pattern byte eff_len-1-j
      k     = PAT_IDX_W'(eff_len - LEN_W'(1) - LEN_W'(j));
      pb    = pat_all[{k, 3'b000} +: BYTE_W];
      eq[j] = (sh_byte[j] == pb) || (LEN_W'(j) >= eff_len);
    end
    hit = (eff_len != '0) && (nf >= eff_len) && (bsm_inc >= eff_len) && (&eq);
  end

  // Next window state
  always_comb begin
    win_byte_nxt = win_byte_r;
    win_mask_nxt = win_mask_r;
    win_fill_nxt = win_fill_r;
    rel_cnt_nxt  = rel_cnt_r - LEN_W'(drain_go);
    rel_last_nxt = rel_last_r;
    bsm_nxt      = bsm_r;
    released     = '0;
    if (in_tlast || (eff_len == '0)) begin
      released = nf;
    end else if (nf >= eff_len) begin
      released = nf - eff_len + LEN_W'(1);
    end
    if (in_acc) begin
      win_byte_nxt = sh_byte;
      for (int j = 0; j < DEPTH; j++) begin
        win_mask_nxt[j] = sh_mask[j] | (hit && (LEN_W'(j) < eff_len));
      end
      win_fill_nxt = nf - released;
      // any earlier release drains in this same cycle
      rel_cnt_nxt  = released;
      rel_last_nxt = in_tlast;
      if (in_tlast) begin
        bsm_nxt = PAT_CAP_L;
      end else if (hit) begin
        bsm_nxt = '0;
      end else begin
        bsm_nxt = bsm_inc;
      end
    end
  end

  // Two-entry output buffer
  always_comb begin
    pop         = (ob_cnt_r != 2'd0) && out_tready;
    ob_head_nxt = ob_head_r;
    ob_tail_nxt = ob_tail_r;
    ob_cnt_nxt  = ob_cnt_r;
    unique case ({drain_go, pop})
      2'b01: begin
        ob_head_nxt = ob_tail_r;
        ob_cnt_nxt  = ob_cnt_r - 2'd1;
      end
      2'b10: begin
        if (ob_cnt_r == 2'd0) begin
          ob_head_nxt = drain_item;
        end else begin
          ob_tail_nxt = drain_item;
        end
        ob_cnt_nxt = ob_cnt_r + 2'd1;
      end
      2'b11: begin
        if (ob_cnt_r == 2'd1) begin
          ob_head_nxt = drain_item;
        end else begin
          ob_head_nxt = ob_tail_r;
          ob_tail_nxt = drain_item;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = (ob_cnt_r != 2'd0);
  assign out_tdata  = ob_head_r.data;
  assign out_tlast  = ob_head_r.last;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r  <= '0;
      pat_hi_r  <= '0;
      pat_len_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PAT_LO:  pat_lo_r  <= cfg_wdata;
        REG_PAT_HI:  pat_hi_r  <= cfg_wdata;
        REG_PAT_LEN: pat_len_r <= cfg_wdata[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_mask_r <= '0;
      win_fill_r <= '0;
      rel_cnt_r  <= '0;
      rel_last_r <= 1'b0;
      bsm_r      <= PAT_CAP_L;
      ob_cnt_r   <= 2'd0;
    end else begin
      win_mask_r <= win_mask_nxt;
      win_fill_r <= win_fill_nxt;
      rel_cnt_r  <= rel_cnt_nxt;
      rel_last_r <= rel_last_nxt;
      bsm_r      <= bsm_nxt;
      ob_cnt_r   <= ob_cnt_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    win_byte_r <= win_byte_nxt;
    ob_head_r  <= ob_head_nxt;
    ob_tail_r  <= ob_tail_nxt;
  end

  // Checks
  `SPM_ASSERT_ALWAYS(a_line_bound, total <= DEPTH_L, "window line overflow")
  `SPM_ASSERT_ALWAYS(a_ob_bound, ob_cnt_r != 2'd3, "output buffer count out of range")
  `SPM_ASSERT_NEXT(a_last_flush, in_acc && in_tlast, (win_fill_r == '0) && (bsm_r == PAT_CAP_L), "end of stream left bytes in the window")
  `SPM_ASSERT_NEXT(a_hit_resets, in_acc && hit && !in_tlast, bsm_r == '0, "match did not restart the overlap guard")

endmodule

>>> test/tb.sv
// ---------------------------------------------------------------------------
// Stream pattern masker - testbench
// Drives byte streams into the masker core and checks every output byte and
// its last flag against a behavioural model of the redaction window. A short
// directed part covers zero length, overlapping repeats, over-range length
// and a length cut on a partly held window. Random phases follow: a new
// pattern and length is loaded between phases while the core is idle.
// The sender works in bursts, and the receiver stalls on its own schedule,
// including one long hold-off that backs the core up into its input.
// ---------------------------------------------------------------------------
module tb;
  import spm_pkg::*;

  localparam int DRAIN_CYCLES = 40;   // quiet cycles before a register write
  localparam int HOLD_CYCLES  = 300;  // long receiver hold-off
  localparam int RANDOM_ITEMS = 190;
  localparam int WIN_DEPTH    = MAX_PATTERN_DEF;

  typedef struct packed {
    logic              last;
    logic [BYTE_W-1:0] data;
  } stream_byte_t;

  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HALF, RX_HEAVY} rx_mode_t;

  // DUT signals
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata   = '0;  // [7:0] in_byte
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [BYTE_W-1:0]     out_tdata;        // [7:0] out_byte
  logic                  out_tlast;
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = REG_PAT_LO;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  // Model of the redaction window
  logic [BYTE_W-1:0]     win_data [WIN_DEPTH];
  logic                  win_mark [WIN_DEPTH];
  int unsigned           win_fill;
  int unsigned           since_match;
  logic [CFG_DATA_W-1:0] pat_lo_q;
  logic [CFG_DATA_W-1:0] pat_hi_q;
  logic [LEN_W-1:0]      pat_len_q;

  out_item_t    masked_expected[$];
  stream_byte_t pending[$];
  stream_byte_t phase_items[$];

  // Handshake and pacing state
  bit          in_taken   = 1'b0;
  bit          hold_req   = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;
  int unsigned rx_left    = 0;
  rx_mode_t    rx_mode    = RX_OPEN;
  int unsigned frame_left = 1;

  // Run statistics
  int unsigned errors   = 0;
  int unsigned n_in     = 0;
  int unsigned n_out    = 0;
  int unsigned n_frames = 0;
  int unsigned n_hits   = 0;
  int unsigned n_phases = 0;

  stream_pattern_masker_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    #4000000;
    $display("%0t: timeout, output stream did not drain", $time);
    $display("*** FAILED ***");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Window model
  // -------------------------------------------------------------------------
  function automatic logic [BYTE_W-1:0] pattern_at(input int unsigned idx);
    if (idx < 8) return pat_lo_q[8*idx +: 8];
    return pat_hi_q[8*(idx-8) +: 8];
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < WIN_DEPTH; i++) begin
      win_data[i] = '0;
      win_mark[i] = 1'b0;
    end
    win_fill    = 0;
    since_match = PAT_CAP;
  endfunction

  // oldest held byte leaves, starred if it belongs to a match
  function automatic void emit_oldest(input logic last);
    out_item_t item;
    item.data = win_mark[0] ? MASK_BYTE : win_data[0];
    item.last = last;
    masked_expected.push_back(item);
    for (int i = 1; i < win_fill; i++) begin
      win_data[i-1] = win_data[i];
      win_mark[i-1] = win_mark[i];
    end
    win_fill--;
    win_mark[win_fill] = 1'b0;
  endfunction

  function automatic void predict_masked(input logic [BYTE_W-1:0] b, input logic last);
    int unsigned len;
    int unsigned base;
    logic        hit;
    len = (pat_len_q > PAT_CAP) ? PAT_CAP : pat_len_q;
    if (len > WIN_DEPTH) len = WIN_DEPTH;
    // keep room for the new byte (a full line never occurs in practice)
    if (win_fill >= WIN_DEPTH) emit_oldest(1'b0);
    win_data[win_fill] = b;
    win_mark[win_fill] = 1'b0;
    win_fill++;
    if (since_match < PAT_CAP) since_match++;
    // compare the newest len bytes, unless they overlap an earlier match
    if (len > 0 && win_fill >= len && since_match >= len) begin
      base = win_fill - len;
      hit  = 1'b1;
      for (int i = 0; i < len; i++)
        if (win_data[base+i] != pattern_at(i)) hit = 1'b0;
      if (hit) begin
        for (int i = 0; i < len; i++) win_mark[base+i] = 1'b1;
        since_match = 0;
        n_hits++;
      end
    end
    if (last) begin
      while (win_fill > 0) emit_oldest(win_fill == 1);
      for (int i = 0; i < WIN_DEPTH; i++) win_mark[i] = 1'b0;
      since_match = PAT_CAP;
    end else begin
      while (win_fill > 0 && win_fill >= len) emit_oldest(1'b0);
    end
  endfunction

  // -------------------------------------------------------------------------
  // Monitor: register writes, input transactions and output checks
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    out_item_t want;
    in_taken = 1'b0;
    if (!rst_n) begin
      clear_window();
      pat_lo_q  = '0;
      pat_hi_q  = '0;
      pat_len_q = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_PAT_LO:  pat_lo_q  = cfg_wdata;
          REG_PAT_HI:  pat_hi_q  = cfg_wdata;
          REG_PAT_LEN: pat_len_q = cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        in_taken = 1'b1;
        n_in++;
        if (in_tlast) n_frames++;
        predict_masked(in_tdata, in_tlast);
      end
      if (out_tvalid && out_tready) begin
        n_out++;
        if (masked_expected.size() == 0) begin
          errors++;
          $display("%0t: unexpected output, expected none, actual byte %02h last %b",
                   $time, out_tdata, out_tlast);
        end else begin
          want = masked_expected.pop_front();
          if (out_tdata !== want.data) begin
            errors++;
            $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                     $time, want.data, out_tdata);
          end
          if (out_tlast !== want.last) begin
            errors++;
            $display("%0t: out_last mismatch, expected %b, actual %b",
                     $time, want.last, out_tlast);
          end
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Driver: bursts of bytes with random gaps
  // -------------------------------------------------------------------------
  always @(negedge clk) begin : driver
    stream_byte_t next_item;
    if (!(in_tvalid && !in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending.size() > 0) begin
        next_item = pending.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= next_item.data;
        in_tlast  <= next_item.last;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Receiver: stall schedule of its own, plus one long hold-off on request
  // -------------------------------------------------------------------------
  always @(negedge clk) begin : receiver
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(8, 64);
      end
      rx_left--;
      case (rx_mode)
        RX_OPEN:  out_tready <= 1'b1;
        RX_LIGHT: out_tready <= ($urandom_range(0, 7) != 0);
        RX_HALF:  out_tready <= 1'($urandom_range(0, 1));
        default:  out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  task automatic load_pattern(input logic [CFG_DATA_W-1:0] lo,
                              input logic [CFG_DATA_W-1:0] hi,
                              input logic [LEN_W-1:0]      len);
    write_reg(REG_PAT_LO, lo);
    write_reg(REG_PAT_HI, hi);
    write_reg(REG_PAT_LEN, CFG_DATA_W'(len));
    cfg_we <= 1'b0;
    n_phases++;
  endtask

  // all offered, all results back, then a quiet spell
  task automatic wait_idle();
    do @(negedge clk);
    while (pending.size() != 0 || in_tvalid || masked_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_phase(input bit with_hold);
    foreach (phase_items[i]) pending.push_back(phase_items[i]);
    phase_items.delete();
    if (with_hold) hold_req = 1'b1;
    wait_idle();
  endtask

  // random frame boundaries inside a phase
  function automatic void add_byte(input logic [BYTE_W-1:0] b);
    phase_items.push_back({frame_left == 1, b});
    if (frame_left <= 1) frame_left = $urandom_range(1, 30);
    else frame_left--;
  endfunction

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin : stimulus
    logic [BYTE_W-1:0]     pat [PAT_CAP];
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    logic [LEN_W-1:0]      len;
    logic [BYTE_W-1:0]     base;
    int unsigned           eff;
    int unsigned           pick;
    int unsigned           corrupt;
    int unsigned           phase_len;
    int unsigned           random_sent;
    int unsigned           random_phase;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero length: everything passes straight through, star byte included
    load_pattern('0, '1, 5'd0);
    phase_items.push_back({1'b0, 8'h00});
    phase_items.push_back({1'b0, 8'hFF});
    phase_items.push_back({1'b1, MASK_BYTE});
    send_phase(1'b0);

    // overlapping repeats: only leftmost non-overlapping hits are starred
    load_pattern(64'h6161, '0, 5'd2);
    for (int i = 0; i < 5; i++) phase_items.push_back({i == 4, 8'h61});
    send_phase(1'b0);

    // length above sixteen, full-width pattern, stream left open
    load_pattern(64'h0706050403020100, 64'h0F0E0D0C0B0A0908, 5'd31);
    for (int i = 0; i < 16; i++) phase_items.push_back({1'b0, 8'(i)});
    send_phase(1'b0);

    // length and pattern cut mid-stream, surplus drains, then flush
    load_pattern(64'h6161, '1, 5'd2);
    phase_items.push_back({1'b0, 8'h61});
    phase_items.push_back({1'b1, 8'h61});
    send_phase(1'b0);

    // random phases
    random_sent  = 0;
    random_phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)      len = 5'd0;
      else if (pick < 6)  len = LEN_W'($urandom_range(1, 4));
      else if (pick == 6) len = 5'd16;
      else if (pick == 7) len = LEN_W'($urandom_range(17, 31));
      else if (pick == 8) len = LEN_W'($urandom_range(5, 15));
      else                len = 5'd1;
      eff = (len > PAT_CAP) ? PAT_CAP : len;

      // pattern: all ones, all zeros, or a small alphabet that overlaps itself
      pick = $urandom_range(0, 7);
      base = 8'($urandom_range(0, 255));
      for (int i = 0; i < PAT_CAP; i++) begin
        if (pick == 0)      pat[i] = 8'hFF;
        else if (pick == 1) pat[i] = 8'h00;
        else if (i < eff)   pat[i] = base + 8'($urandom_range(0, 2));
        else                pat[i] = 8'($urandom_range(0, 255));
      end
      for (int i = 0; i < 8; i++) begin
        lo[8*i +: 8] = pat[i];
        hi[8*i +: 8] = pat[i+8];
      end
      load_pattern(lo, hi, len);

      // mostly whole or broken copies of the pattern, some noise
      phase_len = $urandom_range(10, 40);
      while (phase_items.size() < phase_len) begin
        pick = $urandom_range(0, 9);
        if (eff > 0 && pick < 5) begin
          corrupt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, eff - 1) : eff;
          for (int i = 0; i < eff; i++)
            add_byte((i == corrupt) ? 8'($urandom_range(0, 255)) : pat[i]);
        end else if (eff > 0 && pick < 8) begin
          add_byte(pat[$urandom_range(0, eff - 1)]);
        end else begin
          add_byte(8'($urandom_range(0, 255)));
        end
      end
      random_sent += phase_items.size();
      // most phases close the stream; some leave bytes held for the next one
      if (random_sent >= RANDOM_ITEMS || $urandom_range(0, 3) != 0) begin
        phase_items[phase_items.size()-1].last = 1'b1;
        frame_left = $urandom_range(1, 30);
      end
      send_phase(random_phase == 2);
      random_phase++;
    end

    $display("Run covered %0d input and %0d output transactions in %0d streams",
             n_in, n_out, n_frames);
    $display("with %0d pattern hits over %0d register settings", n_hits, n_phases);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
